@@ rtl/core/bsbd_pkg.sv @@
// Package: action and condition codes, transaction payload types and carry state type for the add/sub block.
package bsbd_pkg;

	localparam logic [1:0] ACT_BIN_ADD = 2'd0;
	localparam logic [1:0] ACT_BIN_SUB = 2'd1;
	localparam logic [1:0] ACT_DEC_ADD = 2'd2;
	localparam logic [1:0] ACT_DEC_SUB = 2'd3;

	localparam logic [1:0] CC_NEGATIVE = 2'd1;
	localparam logic [1:0] CC_ZERO     = 2'd2;
	localparam logic [1:0] CC_POSITIVE = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] a_byte;
		logic [7:0] b_byte;
		logic       b_in_field;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] result_byte;
		logic [1:0] cond_code;
		logic       field_done;
	} out_t;

	typedef struct packed {
		logic [1:0] carry_or_borrow;
		logic       any_nonzero;
	} acc_t;

endpackage

@@ rtl/core/bsbd_alu.sv @@
// Byte datapath: binary and zoned decimal add/subtract for one byte position plus condition code.
module bsbd_alu (
	input  bsbd_pkg::in_t  item,
	input  bsbd_pkg::acc_t acc,
	output bsbd_pkg::out_t res,
	output bsbd_pkg::acc_t acc_next
);

	logic [7:0]  b_eff;
	logic [9:0]  bin_sum;
	logic [10:0] bin_diff;
	logic [5:0]  dec_sum;
	logic [5:0]  dec_diff;
	logic [5:0]  dec_diff_adj;
	logic [3:0]  dec_sum_dig;
	logic [1:0]  dec_sum_carry;
	logic [7:0]  byte_out;
	logic [1:0]  cout;
	logic        nz;
	logic        sub;
	logic        nz_acc;

	assign b_eff = item.b_in_field ? item.b_byte : 8'd0;

	assign bin_sum  = {2'b00, item.a_byte} + {2'b00, b_eff} + {8'd0, acc.carry_or_borrow};
	assign bin_diff = {3'b000, item.a_byte} - {3'b000, b_eff} - {9'd0, acc.carry_or_borrow};

	// low nibbles only; sum tops out at 33, so three compares give quotient and digit
	assign dec_sum  = {2'b00, item.a_byte[3:0]} + {2'b00, b_eff[3:0]}
		+ {4'd0, acc.carry_or_borrow};
	assign dec_diff = {2'b00, item.a_byte[3:0]} - {2'b00, b_eff[3:0]}
		- {4'd0, acc.carry_or_borrow};
	assign dec_diff_adj = dec_diff + 6'd10;

	always_comb begin
		priority if (dec_sum >= 6'd30) begin
			dec_sum_carry = 2'd3;
			dec_sum_dig   = 4'(dec_sum - 6'd30);
		end else if (dec_sum >= 6'd20) begin
			dec_sum_carry = 2'd2;
			dec_sum_dig   = 4'(dec_sum - 6'd20);
		end else if (dec_sum >= 6'd10) begin
			dec_sum_carry = 2'd1;
			dec_sum_dig   = 4'(dec_sum - 6'd10);
		end else begin
			dec_sum_carry = 2'd0;
			dec_sum_dig   = dec_sum[3:0];
		end
	end

	always_comb begin
		unique case (item.action)
			bsbd_pkg::ACT_BIN_ADD: begin
				byte_out = bin_sum[7:0];
				cout     = bin_sum[9:8];
				nz       = (bin_sum[7:0] != 8'd0);
			end
			bsbd_pkg::ACT_BIN_SUB: begin
				byte_out = bin_diff[7:0];
				cout     = {1'b0, bin_diff[10]};
				nz       = (bin_diff[7:0] != 8'd0);
			end
			bsbd_pkg::ACT_DEC_ADD: begin
				byte_out = {item.a_byte[7:4], dec_sum_dig};
				cout     = dec_sum_carry;
				nz       = (dec_sum_dig != 4'd0);
			end
			default: begin
				// negative difference gets ten added once; zone kept as is
				byte_out = {item.a_byte[7:4],
					dec_diff[5] ? dec_diff_adj[3:0] : dec_diff[3:0]};
				cout     = {1'b0, dec_diff[5]};
				nz       = dec_diff[5] ? (dec_diff_adj[3:0] != 4'd0)
					: (dec_diff[3:0] != 4'd0);
			end
		endcase
	end

	assign sub    = item.action[0];
	assign nz_acc = acc.any_nonzero | nz;

	always_comb begin
		res.result_byte = byte_out;
		res.field_done  = item.last_byte;
		res.cond_code   = 2'd0;
		if (item.last_byte) begin
			if (!sub) begin
				res.cond_code = {(cout != 2'd0), nz_acc};
			end else if (cout != 2'd0) begin
				res.cond_code = bsbd_pkg::CC_NEGATIVE;
			end else if (!nz_acc) begin
				res.cond_code = bsbd_pkg::CC_ZERO;
			end else begin
				res.cond_code = bsbd_pkg::CC_POSITIVE;
			end
		end
		if (item.last_byte) begin
			acc_next = '0;
		end else begin
			acc_next.carry_or_borrow = cout;
			acc_next.any_nonzero     = nz_acc;
		end
	end

endmodule

@@ rtl/core/byte_serial_binary_decimal_add_sub.sv @@
// Top level: input register, byte datapath, result register and carry/nonzero state.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid / in_ready     | in_data  (bsbd_pkg::in_t)
//   out     | output    | out_valid / out_ready   | out_data (bsbd_pkg::out_t)
//
// One byte per cycle unless the output stalls; input register, then result register.
// The carry/nonzero state is updated as a byte moves from the input register into the
// result register, so consecutive bytes chain through that single register.
// Reset clears both valid flags and the carry/nonzero state.
// A stalled output backs up the input register, then in_ready drops.
module byte_serial_binary_decimal_add_sub (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bsbd_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output bsbd_pkg::out_t out_data
);

	bsbd_pkg::in_t  item_s1;
	logic           valid_s1;
	bsbd_pkg::out_t res_s2;
	logic           valid_s2;
	bsbd_pkg::acc_t acc_q;
	bsbd_pkg::out_t res_next;
	bsbd_pkg::acc_t acc_next;
	logic           adv_s2;

	assign adv_s2   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s2;

	bsbd_alu u_alu (
		.item     (item_s1),
		.acc      (acc_q),
		.res      (res_next),
		.acc_next (acc_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			acc_q    <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
				acc_q    <= acc_next;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
		if (adv_s2) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	// condition code only on the closing byte of a field
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.field_done) |-> (res_s2.cond_code == 2'd0))
		else $error("cond_code set on a non-final byte");

	// state is cleared once the last byte leaves the datapath
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && item_s1.last_byte) |=> (acc_q == '0))
		else $error("carry/nonzero state not cleared after last byte");

	// state moves only with a byte
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s2 |=> $stable(acc_q))
		else $error("carry/nonzero state changed without a byte");

	// an empty input register always takes a transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled while input register empty");

endmodule

@@ sim/byte_serial_binary_decimal_add_sub_tb.sv @@
// Self-checking testbench for the byte-serial binary/zoned-decimal add/subtract block.
module byte_serial_binary_decimal_add_sub_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int RANDOM_BYTES   = 1350;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	bsbd_pkg::in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	bsbd_pkg::out_t out_data;

	byte_serial_binary_decimal_add_sub uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// pending bytes, with a flag that holds the byte back until all results are in
	bsbd_pkg::in_t  pend_q[$];
	bit             drain_q[$];
	bsbd_pkg::out_t expected_q[$];

	// predictor state: carry/borrow into the next position and nonzero mark
	logic [1:0] carry_st = '0;
	logic       nz_st = 1'b0;

	int errors = 0;
	int n_bytes = 0;
	int n_fields = 0;
	int n_checked = 0;
	int act_cnt[4] = '{0, 0, 0, 0};
	int stall_cycles = 0;
	bit in_taken = 0;
	int burst_left = 1;
	int gap_left = 0;
	int rx_mode = 0;
	int rx_left = 0;

	function automatic bsbd_pkg::out_t predict_byte(bsbd_pkg::in_t it);
		logic [7:0] bv;
		logic [7:0] res;
		logic [9:0] s;
		logic [1:0] cout;
		logic [3:0] dig;
		logic       nz;
		int         d;
		bsbd_pkg::out_t o;
		bv = it.b_in_field ? it.b_byte : 8'h00;
		case (it.action)
			bsbd_pkg::ACT_BIN_ADD: begin
				s = {2'b00, it.a_byte} + {2'b00, bv} + {8'd0, carry_st};
				res = s[7:0];
				cout = s[9:8];
				nz = (res != 0);
			end
			bsbd_pkg::ACT_BIN_SUB: begin
				d = int'(it.a_byte) - int'(bv) - int'(carry_st);
				cout = (d < 0) ? 2'd1 : 2'd0;
				res = d[7:0];
				nz = (res != 0);
			end
			bsbd_pkg::ACT_DEC_ADD: begin
				s = {6'd0, it.a_byte[3:0]} + {6'd0, bv[3:0]} + {8'd0, carry_st};
				dig = 4'(s % 10);
				cout = 2'(s / 10);
				res = {it.a_byte[7:4], dig};
				nz = (dig != 0);
			end
			default: begin
				d = int'(it.a_byte[3:0]) - int'(bv[3:0]) - int'(carry_st);
				if (d < 0) begin
					d += 10;
					cout = 2'd1;
				end else begin
					cout = 2'd0;
				end
				dig = d[3:0];
				res = {it.a_byte[7:4], dig};
				nz = (dig != 0);
			end
		endcase
		nz_st = nz_st | nz;
		carry_st = cout;
		o.result_byte = res;
		o.field_done = it.last_byte;
		o.cond_code = 2'd0;
		if (it.last_byte) begin
			if (!it.action[0])
				o.cond_code = {carry_st != 0, nz_st};
			else if (carry_st != 0)
				o.cond_code = bsbd_pkg::CC_NEGATIVE;
			else if (!nz_st)
				o.cond_code = bsbd_pkg::CC_ZERO;
			else
				o.cond_code = bsbd_pkg::CC_POSITIVE;
			carry_st = '0;
			nz_st = 1'b0;
		end
		return o;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic push_byte(logic [1:0] act, logic [7:0] a, logic [7:0] b, logic bin,
			logic last, bit drain = 0);
		bsbd_pkg::in_t it;
		it = '{action: act, a_byte: a, b_byte: b, b_in_field: bin, last_byte: last};
		pend_q.push_back(it);
		drain_q.push_back(drain);
		n_bytes++;
		act_cnt[act]++;
		if (last)
			n_fields++;
	endtask

	// decimal operands are mostly zoned digits, with the odd nibble above nine
	function automatic logic [7:0] rand_byte(logic dec);
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 8'h00;
		if (pick == 1)
			return 8'hFF;
		if (dec && $urandom_range(0, 9) != 0)
			return {($urandom_range(0, 1) ? 4'hF : 4'($urandom_range(0, 15))),
				4'($urandom_range(0, 9))};
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic gen_field(bit drain);
		int len;
		int blen;
		int i;
		logic [1:0] act;
		logic [7:0] a;
		logic [7:0] b;
		logic bin;
		len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
		blen = ($urandom_range(0, 2) == 0) ? $urandom_range(1, len) : len;
		act = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 11) == 0) begin
			// noise: random bytes, stray last flags, operand flag at random
			for (i = 0; i < len; i++)
				push_byte(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					$urandom_range(0, 3) == 0, drain && i == 0);
		end else begin
			for (i = 0; i < len; i++) begin
				if ($urandom_range(0, 24) == 0)
					act = 2'($urandom_range(0, 3));
				a = rand_byte(act[1]);
				bin = (i < blen);
				if (!bin)
					b = 8'($urandom_range(0, 255));
				else if (act[0] && $urandom_range(0, 4) == 0)
					b = a;
				else
					b = rand_byte(act[1]);
				push_byte(act, a, b, bin, i == len - 1, drain && i == 0);
			end
		end
	endtask

	// sender: bursts of transactions separated by random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
			// hold until accepted
		end else if (gap_left > 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (pend_q.size() != 0 && drain_q[0] && expected_q.size() != 0) begin
			in_valid <= 1'b0;
		end else if (pend_q.size() != 0) begin
			in_data <= pend_q.pop_front();
			void'(drain_q.pop_front());
			in_valid <= 1'b1;
			if (burst_left > 1) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(1, 24);
				gap_left = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver: stall pattern switches between full rate, light, heavy and near-blocked
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(32, 256);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		bsbd_pkg::out_t got;
		bsbd_pkg::out_t want;
		in_taken = arst_n && in_valid && in_ready;
		if (in_taken)
			expected_q.push_back(predict_byte(in_data));
		if (arst_n && out_valid && out_ready) begin
			got = out_data;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result byte %02h", got.result_byte));
			end else begin
				want = expected_q.pop_front();
				n_checked++;
				if (got.result_byte !== want.result_byte)
					report_mismatch($sformatf("result_byte %02h, expected %02h",
						got.result_byte, want.result_byte));
				if (got.cond_code !== want.cond_code)
					report_mismatch($sformatf("cond_code %0d, expected %0d",
						got.cond_code, want.cond_code));
				if (got.field_done !== want.field_done)
					report_mismatch($sformatf("field_done %0b, expected %0b",
						got.field_done, want.field_done));
			end
		end
		if (!arst_n || in_taken || (out_valid && out_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
					stall_cycles, expected_q.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		// binary add: carry out of one byte, all zero, carry chained across two bytes
		push_byte(bsbd_pkg::ACT_BIN_ADD, 8'hFF, 8'hFF, 1'b1, 1'b1);
		push_byte(bsbd_pkg::ACT_BIN_ADD, 8'h00, 8'h00, 1'b1, 1'b1);
		push_byte(bsbd_pkg::ACT_BIN_ADD, 8'hFF, 8'h01, 1'b1, 1'b0);
		push_byte(bsbd_pkg::ACT_BIN_ADD, 8'h00, 8'hFF, 1'b0, 1'b1);
		// binary subtract: negative, zero, positive
		push_byte(bsbd_pkg::ACT_BIN_SUB, 8'h00, 8'h01, 1'b1, 1'b1);
		push_byte(bsbd_pkg::ACT_BIN_SUB, 8'h55, 8'h55, 1'b1, 1'b1);
		push_byte(bsbd_pkg::ACT_BIN_SUB, 8'h07, 8'h03, 1'b1, 1'b0);
		push_byte(bsbd_pkg::ACT_BIN_SUB, 8'h00, 8'hAA, 1'b0, 1'b1);
		// decimal add with carry, then digits above nine giving carry three
		push_byte(bsbd_pkg::ACT_DEC_ADD, 8'hF9, 8'hF9, 1'b1, 1'b0);
		push_byte(bsbd_pkg::ACT_DEC_ADD, 8'hF9, 8'hF9, 1'b1, 1'b1);
		push_byte(bsbd_pkg::ACT_DEC_ADD, 8'h0F, 8'hFF, 1'b1, 1'b0);
		push_byte(bsbd_pkg::ACT_DEC_ADD, 8'h0F, 8'h0F, 1'b1, 1'b1);
		push_byte(bsbd_pkg::ACT_DEC_ADD, 8'hF0, 8'hF0, 1'b1, 1'b1);
		// decimal subtract: borrow, borrow into nibble above nine, zero result
		push_byte(bsbd_pkg::ACT_DEC_SUB, 8'h30, 8'h39, 1'b1, 1'b0);
		push_byte(bsbd_pkg::ACT_DEC_SUB, 8'hF0, 8'hFF, 1'b1, 1'b1);
		push_byte(bsbd_pkg::ACT_DEC_SUB, 8'hF5, 8'hF5, 1'b1, 1'b1);
		push_byte(bsbd_pkg::ACT_DEC_SUB, 8'h5F, 8'h00, 1'b1, 1'b1);
		// action switched mid-field: carry three into binary add, borrow into decimal add
		push_byte(bsbd_pkg::ACT_DEC_ADD, 8'h0F, 8'h0F, 1'b1, 1'b0);
		push_byte(bsbd_pkg::ACT_BIN_ADD, 8'hFF, 8'hFF, 1'b1, 1'b0);
		push_byte(bsbd_pkg::ACT_BIN_SUB, 8'h00, 8'h02, 1'b1, 1'b0);
		push_byte(bsbd_pkg::ACT_DEC_ADD, 8'hA5, 8'h5A, 1'b1, 1'b0);
		push_byte(bsbd_pkg::ACT_DEC_SUB, 8'hFF, 8'h00, 1'b0, 1'b1);

		// random fields; the first waits for the directed results to drain
		gen_field(1'b1);
		while (n_bytes < RANDOM_BYTES + 22)
			gen_field($urandom_range(0, 49) == 0);

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		while (pend_q.size() != 0 || in_valid || expected_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_q.size()));

		$display("Covered %0d bytes, %0d fields: add %0d, sub %0d, dec add %0d, dec sub %0d",
			n_bytes, n_fields, act_cnt[bsbd_pkg::ACT_BIN_ADD],
			act_cnt[bsbd_pkg::ACT_BIN_SUB], act_cnt[bsbd_pkg::ACT_DEC_ADD],
			act_cnt[bsbd_pkg::ACT_DEC_SUB]);
		$display("%0d results compared, %0d mismatches", n_checked, errors);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
